@@ rtl/core/erq_pkg.sv @@
// Shared types, constants and helpers for the event ring queue.
// Depends on nothing; every other file of the block imports this package.
package erq_pkg;

    localparam int DEPTH     = 32;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CODE_W    = 5;
    localparam int ARG_W     = 32;
    localparam int NUM_SLOTS = 4;
    localparam int SLOT_W    = 2;
    localparam int FILL_W    = 5;
    localparam int CNT_W     = (PTR_W > FILL_W) ? PTR_W : FILL_W;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_GET  = 2'd1,
        OP_SET  = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]              operation;
        logic [CODE_W-1:0]       event_code;
        logic signed [ARG_W-1:0] arg0;
        logic signed [ARG_W-1:0] arg1;
        logic signed [ARG_W-1:0] arg2;
        logic signed [ARG_W-1:0] arg3;
        logic [SLOT_W-1:0]       slot_select;
        logic signed [ARG_W-1:0] slot_value;
    } in_t;

    typedef struct packed {
        logic                    got_entry;
        logic [CODE_W-1:0]       out_code;
        logic signed [ARG_W-1:0] out_arg0;
        logic signed [ARG_W-1:0] out_arg1;
        logic signed [ARG_W-1:0] out_arg2;
        logic signed [ARG_W-1:0] out_arg3;
        logic                    dropped_oldest;
        logic [FILL_W-1:0]       fill_level;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic put;
        logic get_take;
        logic walk_init;
        logic walk_step;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic empty;
        logic walk_last;
    } status_t;

    function automatic ptr_t ring_next(input ptr_t p);
        ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

@@ rtl/core/event_ring_queue_drop_oldest.sv @@
// Top level of the event ring queue that drops the oldest entry on overflow.
// Depends on erq_pkg, erq_ctrl and erq_datapath.
//
//   channel   handshake          payload   direction
//   request   start / busy       in_t      in
//   result    done (strobe)      out_t     out
//
// A put, a get on an empty queue or an unused operation code passes from accept
// through the decode and done states, a get that returns an entry also through the
// get state, and a set-param through one walk step per queued entry, since the
// entries are rewritten one a cycle through the single write port of each memory.
// The result strobe is high for one cycle, the first cycle in which busy is low.
// Reset clears both pointers; the entry memories need no clearing pass.
// The receiver cannot stall, so the result register is simply overwritten.
module event_ring_queue_drop_oldest (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  erq_pkg::in_t  request,
    output logic          done,
    output erq_pkg::out_t result
);
    import erq_pkg::*;

    cmd_t    cmd;
    status_t status;

    erq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    erq_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .done    (done),
        .result  (result)
    );

endmodule

@@ rtl/core/erq_ctrl.sv @@
// Controller state machine for the event ring queue.
// Depends on erq_pkg for the command, status and operation types.
module erq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  erq_pkg::status_t status,
    output erq_pkg::cmd_t    cmd
);
    import erq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_GET    = 5'b00100,
        S_SET    = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.op)
                    OP_PUT:
                    begin
                        cmd.put    = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_GET:
                    begin
                        state_next = status.empty ? S_DONE : S_GET;
                    end
                    OP_SET:
                    begin
                        if (!status.empty)
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_SET;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_GET:
            begin
                cmd.get_take = 1'b1;
                state_next   = S_DONE;
            end
            S_SET:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ rtl/core/erq_datapath.sv @@
// Datapath of the event ring queue: pointers, entry memories and result register.
// Depends on erq_pkg for sizes, payload structs and the ring_next helper.
module erq_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  erq_pkg::in_t     request,
    input  erq_pkg::cmd_t    cmd,
    output erq_pkg::status_t status,
    output logic             done,
    output erq_pkg::out_t    result
);
    import erq_pkg::*;

    // Entry memories; contents are only ever used after a put wrote them.
    logic [CODE_W-1:0] code_mem [DEPTH];
    logic [ARG_W-1:0]  arg_mem  [NUM_SLOTS][DEPTH];

    in_t               req_reg;
    ptr_t              wr_ptr_reg;
    ptr_t              wr_ptr_next;
    ptr_t              rd_ptr_reg;
    ptr_t              rd_ptr_next;
    ptr_t              pos_reg;
    ptr_t              put_next_ptr;
    logic              full_put;

    logic [CODE_W-1:0] code_rd_reg;
    logic [ARG_W-1:0]  arg_rd_reg [NUM_SLOTS];
    logic [ARG_W-1:0]  put_arg [NUM_SLOTS];

    logic              got_reg;
    logic              drop_reg;
    logic [CODE_W-1:0] code_reg;
    logic [ARG_W-1:0]  arg_reg [NUM_SLOTS];

    logic              done_reg;
    out_t              result_reg;
    logic [PTR_W-1:0]  fill_ptr;
    logic [CNT_W-1:0]  fill_wide;
    ptr_t              mem_wr_addr;

    assign put_arg[0] = req_reg.arg0;
    assign put_arg[1] = req_reg.arg1;
    assign put_arg[2] = req_reg.arg2;
    assign put_arg[3] = req_reg.arg3;

    assign put_next_ptr = ring_next(wr_ptr_reg);
    assign full_put     = (put_next_ptr == rd_ptr_reg);
    assign mem_wr_addr  = cmd.put ? wr_ptr_reg : pos_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (cmd.put)
        begin
            wr_ptr_next = put_next_ptr;
            if (full_put)
            begin
                rd_ptr_next = ring_next(rd_ptr_reg);
            end
        end
        else if (cmd.get_take)
        begin
            rd_ptr_next = ring_next(rd_ptr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            done_reg   <= cmd.emit;
        end
    end

    // Memory writes and registered reads at the read pointer.
    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            code_mem[wr_ptr_reg] <= req_reg.event_code;
        end
        code_rd_reg <= code_mem[rd_ptr_reg];
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (cmd.put)
            begin
                arg_mem[s][mem_wr_addr] <= put_arg[s];
            end
            else if (cmd.walk_step && (req_reg.slot_select == SLOT_W'(s)))
            begin
                arg_mem[s][mem_wr_addr] <= req_reg.slot_value;
            end
            arg_rd_reg[s] <= arg_mem[s][rd_ptr_reg];
        end
    end

    // Request capture, walk position and the working result.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= request;
            got_reg  <= 1'b0;
            drop_reg <= 1'b0;
            code_reg <= '0;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                arg_reg[s] <= '0;
            end
        end
        if (cmd.put)
        begin
            drop_reg <= full_put;
        end
        if (cmd.get_take)
        begin
            got_reg  <= 1'b1;
            code_reg <= code_rd_reg;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                arg_reg[s] <= arg_rd_reg[s];
            end
        end
        if (cmd.walk_init)
        begin
            pos_reg <= rd_ptr_reg;
        end
        else if (cmd.walk_step)
        begin
            pos_reg <= ring_next(pos_reg);
        end
        if (cmd.emit)
        begin
            result_reg.got_entry      <= got_reg;
            result_reg.out_code       <= code_reg;
            result_reg.out_arg0       <= arg_reg[0];
            result_reg.out_arg1       <= arg_reg[1];
            result_reg.out_arg2       <= arg_reg[2];
            result_reg.out_arg3       <= arg_reg[3];
            result_reg.dropped_oldest <= drop_reg;
            result_reg.fill_level     <= fill_wide[FILL_W-1:0];
        end
    end

    // Occupancy modulo the ring size; pointers never reach DEPTH.
    always_comb
    begin
        if (wr_ptr_reg >= rd_ptr_reg)
        begin
            fill_ptr = wr_ptr_reg - rd_ptr_reg;
        end
        else
        begin
            fill_ptr = PTR_W'(DEPTH) - rd_ptr_reg + wr_ptr_reg;
        end
        fill_wide = CNT_W'(fill_ptr);
    end

    assign status.op        = op_t'(req_reg.operation);
    assign status.empty     = (rd_ptr_reg == wr_ptr_reg);
    assign status.walk_last = (ring_next(pos_reg) == wr_ptr_reg);

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/core/erq_checker.sv @@
// Port-level checker for the event ring queue, bound to the top level.
// Depends on erq_pkg for the payload types and the ring size.
module erq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input erq_pkg::out_t result
);
    import erq_pkg::*;

    // The result strobe only appears once the block is idle again.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Without a returned entry the entry fields read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.got_entry) |-> (result.out_code == '0 && result.out_arg0 == '0
            && result.out_arg1 == '0 && result.out_arg2 == '0 && result.out_arg3 == '0))
        else $error("entry fields not zero without a returned entry");

    // A drop only happens on a put into a full ring, which stays full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.dropped_oldest) |->
            (!result.got_entry && result.fill_level == FILL_W'(DEPTH - 1)))
        else $error("drop reported without a full ring");

    // Two strobes never come in back-to-back cycles.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobes in consecutive cycles");

endmodule

bind event_ring_queue_drop_oldest erq_checker u_erq_checker (.*);
